// ----- design/shrmm_pkg.sv -----
// Package for the sensor history ring: sizes, operation and channel codes,
// record layout, sequencer states and the ring index helper.
// No dependencies.
package shrmm_pkg;

  // Ring size and derived widths
  localparam int HISTORY_DEPTH = 32;
  localparam int IDX_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  // Field widths
  localparam int CO2_W   = 20;
  localparam int TEMP_W  = 13;
  localparam int HUM_W   = 11;
  localparam int VOC_W   = 13;
  localparam int NOX_W   = 13;
  localparam int VALUE_W = 21;
  localparam int MIN_W   = 19;
  localparam int MAX_W   = 20;

  // Minimum starts at 9999.0 in 4 fraction bits
  localparam logic signed [VALUE_W-1:0] MIN_START = 21'sd159984;

  // Operation codes
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_LATEST = 2'd2;

  // Channel codes
  localparam logic [2:0] CH_CO2  = 3'd0;
  localparam logic [2:0] CH_TEMP = 3'd1;
  localparam logic [2:0] CH_HUM  = 3'd2;
  localparam logic [2:0] CH_VOC  = 3'd3;
  localparam logic [2:0] CH_NOX  = 3'd4;

  typedef logic [IDX_W-1:0] idx_t;

  // One stored record (valid flag kept separately in flops)
  typedef struct packed {
    logic        [CO2_W-1:0]  co2;
    logic signed [TEMP_W-1:0] temp;
    logic        [HUM_W-1:0]  hum;
    logic        [VOC_W-1:0]  voc;
    logic        [NOX_W-1:0]  nox;
  } rec_t;

  // Read request from the sequencer to the ring
  typedef struct packed {
    logic en;
    idx_t idx;
  } rd_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_STREAM
  } state_t;

  // Next ring position with wrap
  function automatic idx_t next_idx(input idx_t i);
    idx_t n;
    if (i == IDX_W'(HISTORY_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = i + idx_t'(1);
    end
    return n;
  endfunction

endpackage

// ----- design/shrmm_in_if.sv -----
// Input request channel of the sensor history ring.
// Depends on shrmm_pkg for field widths.
interface shrmm_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          op;
  logic [2:0]                          channel;
  logic        [shrmm_pkg::CO2_W-1:0]  co2_value;
  logic signed [shrmm_pkg::TEMP_W-1:0] temp_value;
  logic        [shrmm_pkg::HUM_W-1:0]  hum_value;
  logic        [shrmm_pkg::VOC_W-1:0]  voc_value;
  logic        [shrmm_pkg::NOX_W-1:0]  nox_value;

  modport source (output valid, op, channel, co2_value, temp_value, hum_value,
                  voc_value, nox_value, input ready);
  modport sink   (input valid, op, channel, co2_value, temp_value, hum_value,
                  voc_value, nox_value, output ready);
endinterface

// ----- design/shrmm_out_if.sv -----
// Result channel of the sensor history ring.
// Depends on shrmm_pkg for field widths.
interface shrmm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [shrmm_pkg::VALUE_W-1:0] value;
  logic signed [shrmm_pkg::MIN_W-1:0]   range_min;
  logic        [shrmm_pkg::MAX_W-1:0]   range_max;
  logic                                 entry_valid;
  logic                                 last;

  modport source (output valid, value, range_min, range_max, entry_valid, last,
                  input ready);
  modport sink   (input valid, value, range_min, range_max, entry_valid, last,
                  output ready);
endinterface

// ----- design/sensor_history_ring_min_max.sv -----
// Sensor history ring with min/max query: top level with the read sequencer
// and the shared compare unit. Depends on shrmm_pkg, shrmm_in_if,
// shrmm_out_if and shrmm_ring.
//
// Keeps the last HISTORY_DEPTH sensor records (CO2, temperature, humidity,
// VOC, NOx, 4 fraction bits each) in a ring. A push is taken in the idle
// state and gives no result. A latest read goes from the idle state through
// the fetch and stream states back to idle and gives one result. A query
// gives HISTORY_DEPTH results, oldest first; the ring has a single read port
// and one entry is read and compared per cycle while the result side is
// ready, and output stalls hold the walk. The last query result carries
// range_min (starts at 9999.0) and range_max (starts at 0); both are zero on
// all other results. Entries never pushed read as zero with entry_valid low.
// A new request is taken only when the sequencer is idle; an unconsumed result
// may still sit in the output register at that time.
module sensor_history_ring_min_max (
  input  logic         clk,
  input  logic         rst_n,
  shrmm_in_if.sink     in_chan,
  shrmm_out_if.source  out_chan
);

  shrmm_pkg::state_t   state_r, state_nxt;
  logic [2:0]          chan_r;
  logic                query_r;
  shrmm_pkg::idx_t     cnt_r;
  shrmm_pkg::idx_t     addr_r;
  logic signed [shrmm_pkg::VALUE_W-1:0] mn_r, mn_nxt;
  logic signed [shrmm_pkg::VALUE_W-1:0] mx_r, mx_nxt;

  logic                                  out_valid_r;
  logic signed [shrmm_pkg::VALUE_W-1:0]  value_r;
  logic signed [shrmm_pkg::MIN_W-1:0]    range_min_r;
  logic        [shrmm_pkg::MAX_W-1:0]    range_max_r;
  logic                                  entry_valid_r;
  logic                                  last_r;

  logic                accept;
  logic                push_en;
  shrmm_pkg::rec_t     push_rec;
  shrmm_pkg::rd_req_t  rd_req;
  shrmm_pkg::idx_t     pos;
  shrmm_pkg::rec_t     rd_rec;
  logic                rd_vld;
  logic                slot_free;
  logic                last_item;
  logic                emit;
  logic                in_ready;
  logic signed [shrmm_pkg::VALUE_W-1:0] sel_val;

  assign accept    = in_chan.valid && in_ready;
  assign slot_free = !out_valid_r || out_chan.ready;
  assign last_item = !query_r || (cnt_r == shrmm_pkg::IDX_W'(shrmm_pkg::HISTORY_DEPTH - 1));

  assign push_rec.co2  = in_chan.co2_value;
  assign push_rec.temp = in_chan.temp_value;
  assign push_rec.hum  = in_chan.hum_value;
  assign push_rec.voc  = in_chan.voc_value;
  assign push_rec.nox  = in_chan.nox_value;

  shrmm_ring u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_en  (push_en),
    .push_rec (push_rec),
    .rd_req   (rd_req),
    .pos      (pos),
    .rd_rec   (rd_rec),
    .rd_vld   (rd_vld)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      shrmm_pkg::ST_IDLE: begin
        if (accept && (in_chan.op == shrmm_pkg::OP_QUERY ||
                       in_chan.op == shrmm_pkg::OP_LATEST)) begin
          state_nxt = shrmm_pkg::ST_FETCH;
        end
      end
      shrmm_pkg::ST_FETCH: begin
        state_nxt = shrmm_pkg::ST_STREAM;
      end
      shrmm_pkg::ST_STREAM: begin
        if (slot_free && last_item) begin
          state_nxt = shrmm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = shrmm_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready   = 1'b0;
    push_en    = 1'b0;
    emit       = 1'b0;
    rd_req.en  = 1'b0;
    rd_req.idx = addr_r;
    unique case (state_r)
      shrmm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        push_en  = in_chan.valid && (in_chan.op == shrmm_pkg::OP_PUSH);
      end
      shrmm_pkg::ST_FETCH: begin
        rd_req.en = 1'b1;
      end
      shrmm_pkg::ST_STREAM: begin
        emit = slot_free;
        if (slot_free && !last_item) begin
          rd_req.en  = 1'b1;
          rd_req.idx = shrmm_pkg::next_idx(addr_r);
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // channel select of the fetched entry; never-pushed entries read zero
  always_comb begin
    sel_val = '0;
    if (rd_vld) begin
      case (chan_r)
        shrmm_pkg::CH_CO2:  sel_val = {1'b0, rd_rec.co2};
        shrmm_pkg::CH_TEMP: sel_val = {{(shrmm_pkg::VALUE_W - shrmm_pkg::TEMP_W)
                                         {rd_rec.temp[shrmm_pkg::TEMP_W-1]}}, rd_rec.temp};
        shrmm_pkg::CH_HUM:  sel_val = {{(shrmm_pkg::VALUE_W - shrmm_pkg::HUM_W){1'b0}},
                                       rd_rec.hum};
        shrmm_pkg::CH_VOC:  sel_val = {{(shrmm_pkg::VALUE_W - shrmm_pkg::VOC_W){1'b0}},
                                       rd_rec.voc};
        shrmm_pkg::CH_NOX:  sel_val = {{(shrmm_pkg::VALUE_W - shrmm_pkg::NOX_W){1'b0}},
                                       rd_rec.nox};
        default:            sel_val = '0;
      endcase
    end
  end

  // shared compare unit: strict min and max
  assign mn_nxt = (sel_val < mn_r) ? sel_val : mn_r;
  assign mx_nxt = (sel_val > mx_r) ? sel_val : mx_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= shrmm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request context, walk position and running range
  always_ff @(posedge clk) begin
    if (accept) begin
      chan_r  <= in_chan.channel;
      query_r <= (in_chan.op == shrmm_pkg::OP_QUERY);
      cnt_r   <= '0;
      mn_r    <= shrmm_pkg::MIN_START;
      mx_r    <= '0;
      addr_r  <= (in_chan.op == shrmm_pkg::OP_QUERY) ? shrmm_pkg::next_idx(pos) : pos;
    end else if (emit) begin
      mn_r <= mn_nxt;
      mx_r <= mx_nxt;
      if (!last_item) begin
        cnt_r  <= cnt_r + shrmm_pkg::idx_t'(1);
        addr_r <= shrmm_pkg::next_idx(addr_r);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      value_r       <= sel_val;
      entry_valid_r <= rd_vld;
      last_r        <= last_item;
      if (query_r && last_item) begin
        range_min_r <= mn_nxt[shrmm_pkg::MIN_W-1:0];
        range_max_r <= mx_nxt[shrmm_pkg::MAX_W-1:0];
      end else begin
        range_min_r <= '0;
        range_max_r <= '0;
      end
    end
  end

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.value       = value_r;
  assign out_chan.range_min   = range_min_r;
  assign out_chan.range_max   = range_max_r;
  assign out_chan.entry_valid = entry_valid_r;
  assign out_chan.last        = last_r;

endmodule

// ----- design/shrmm_ring.sv -----
// Record ring: write position, record memory with one registered read port,
// and per-entry valid flags cleared at reset. Depends on shrmm_pkg.
module shrmm_ring (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_en,
  input  shrmm_pkg::rec_t       push_rec,
  input  shrmm_pkg::rd_req_t    rd_req,
  output shrmm_pkg::idx_t       pos,
  output shrmm_pkg::rec_t       rd_rec,
  output logic                  rd_vld
);

  shrmm_pkg::rec_t                          mem [shrmm_pkg::HISTORY_DEPTH];
  logic [shrmm_pkg::HISTORY_DEPTH-1:0]      vld_r;
  shrmm_pkg::idx_t                          pos_r;
  shrmm_pkg::idx_t                          wr_idx;
  shrmm_pkg::rec_t                          rd_rec_r;
  logic                                     rd_vld_r;

  // push advances first, then writes there
  assign wr_idx = shrmm_pkg::next_idx(pos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      vld_r <= '0;
    end else if (push_en) begin
      pos_r         <= wr_idx;
      vld_r[wr_idx] <= 1'b1;
    end
  end

  // record storage, no reset: a clear flag masks stale contents
  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[wr_idx] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_rec_r <= mem[rd_req.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (rd_req.en) begin
      rd_vld_r <= vld_r[rd_req.idx];
    end
  end

  assign pos    = pos_r;
  assign rd_rec = rd_rec_r;
  assign rd_vld = rd_vld_r;

endmodule
